FILE: hdl/mdiocs_pkg.sv
`timescale 1ns / 1ps

package mdiocs_pkg;

    // Request kinds as they arrive on the input. Code 3 means nothing and is ignored.
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RES_COMMAND = 2'd0,
        RES_DONE    = 2'd1,
        RES_REFUSED = 2'd2
    } t_result_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_REFUSE,
        S_POP
    } t_state;

    // One queued read: notify flag, requester tag and register address.
    typedef struct packed {
        logic        notify;
        logic [7:0]  tag;
        logic [15:0] reg_address;
    } t_entry;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHY_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCESS_MODE = 2'd1;

    localparam logic MODE_GENERIC = 1'b0;
    localparam logic MODE_PAGED   = 1'b1;

    localparam logic [1:0]  OP_WRITE      = 2'd1;
    localparam logic [1:0]  OP_READ       = 2'd2;
    localparam logic [4:0]  REG_MMD_CTRL  = 5'h0D;
    localparam logic [4:0]  REG_MMD_DATA  = 5'h0E;
    localparam logic [4:0]  REG_PAGE      = 5'h16;
    localparam logic [15:0] DIRECT_LIMIT  = 16'h0020;
    localparam logic [15:0] MMD_SET_ADDR  = 16'h001F;
    localparam logic [15:0] MMD_SET_DATA  = 16'h401F;

    localparam int CMD_W = 28;

    // Index of the final command word of a request (number of words minus one).
    function automatic logic [1:0] f_last_step(input logic mode, input logic [15:0] addr);
        logic [1:0] res;
        if (mode == MODE_PAGED) begin
            res = 2'd1;
        end else if (addr < DIRECT_LIMIT) begin
            res = 2'd0;
        end else begin
            res = 2'd3;
        end
        return res;
    endfunction

    function automatic logic [CMD_W-1:0] f_cmd(
        input logic [4:0]  phy,
        input logic        mode,
        input logic        is_read,
        input logic [15:0] addr,
        input logic [15:0] data,
        input logic [1:0]  step
    );
        logic [1:0]  op;
        logic [4:0]  reg5;
        logic [15:0] word;
        logic [1:0]  final_op;
        logic [15:0] final_data;
        final_op   = is_read ? OP_READ : OP_WRITE;
        final_data = is_read ? 16'h0000 : data;
        op   = OP_WRITE;
        reg5 = addr[4:0];
        word = final_data;
        if (mode == MODE_PAGED) begin
            if (step == 2'd0) begin
                reg5 = REG_PAGE;
                word = {8'h00, addr[15:8]};
            end else begin
                op = final_op;
            end
        end else if (addr < DIRECT_LIMIT) begin
            op = final_op;
        end else begin
            case (step)
                2'd0: begin
                    reg5 = REG_MMD_CTRL;
                    word = MMD_SET_ADDR;
                end
                2'd1: begin
                    reg5 = REG_MMD_DATA;
                    word = addr;
                end
                2'd2: begin
                    reg5 = REG_MMD_CTRL;
                    word = MMD_SET_DATA;
                end
                default: begin
                    op   = final_op;
                    reg5 = REG_MMD_DATA;
                end
            endcase
        end
        return {op, phy, reg5, word};
    endfunction

endpackage

FILE: hdl/mdio_command_sequencer.sv
`timescale 1ns / 1ps

// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+------------------------------
// request   | i_kind, i_reg_address, i_write_data, i_requester_tag, i_notify,
//           | i_status_read_valid, i_status_read_data         | start high while busy low
// result    | o_result_kind, o_command_word, o_done_*, o_last | o_strobe, one cycle each
// config    | i_cfg_we, i_cfg_index, i_cfg_data               | taken when i_cfg_we is high
//
// A write or read request is taken in the idle state and then gives its command words
// in turn (one, two or four words) before the sequencer is idle again.
// A status request that pops reads the pending queue memory (its read data is registered)
// and passes the pop state, a refused read the refuse state; other requests stay idle.
// Reset is synchronous, active low; the pending queue memory needs no clearing pass.
// Results cannot be stalled: each one is shown for exactly one cycle.
module mdio_command_sequencer #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_kind,
    input  logic [15:0]                        i_reg_address,
    input  logic [15:0]                        i_write_data,
    input  logic [7:0]                         i_requester_tag,
    input  logic                               i_notify,
    input  logic                               i_status_read_valid,
    input  logic [15:0]                        i_status_read_data,
    input  logic                               i_cfg_we,
    input  logic [mdiocs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mdiocs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                               o_strobe,
    output logic [1:0]                         o_result_kind,
    output logic [mdiocs_pkg::CMD_W-1:0]       o_command_word,
    output logic [15:0]                        o_done_reg_address,
    output logic [15:0]                        o_done_value,
    output logic [7:0]                         o_done_tag,
    output logic                               o_last
);

    localparam int IDX_W   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = $bits(mdiocs_pkg::t_entry);

    // Configuration
    logic [4:0] r_phy_address;
    logic       r_access_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phy_address <= '0;
            r_access_mode <= mdiocs_pkg::MODE_GENERIC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mdiocs_pkg::CFG_PHY_ADDRESS: r_phy_address <= i_cfg_data[4:0];
                mdiocs_pkg::CFG_ACCESS_MODE: r_access_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state
    mdiocs_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         r_step;
    logic [1:0]         r_last_step;
    logic               r_is_read;
    logic [15:0]        r_addr;
    logic [15:0]        r_data;
    logic [15:0]        r_rdata;

    logic               accept;
    logic               full;
    logic               is_write_req;
    logic               is_read_req;
    logic               do_push;
    logic               do_pop;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail;
    logic [IDX_W-1:0]   head_next;
    mdiocs_pkg::t_entry push_entry;
    mdiocs_pkg::t_entry pop_entry;
    logic [ENTRY_W-1:0] rd_data;

    assign busy         = (r_state != mdiocs_pkg::S_IDLE);
    assign accept       = start && !busy;
    assign full         = (r_count == CNT_W'(PENDING_DEPTH));
    assign is_write_req = (i_kind == mdiocs_pkg::KIND_WRITE);
    assign is_read_req  = (i_kind == mdiocs_pkg::KIND_READ);
    assign do_push      = accept && is_read_req && !full;
    assign do_pop       = accept && (i_kind == mdiocs_pkg::KIND_STATUS)
                          && i_status_read_valid && (r_count != '0);

    // The tail index stays below twice the depth, so one compare and subtract wraps it.
    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail      = (tail_sum >= SUM_W'(PENDING_DEPTH))
                       ? IDX_W'(tail_sum - SUM_W'(PENDING_DEPTH))
                       : IDX_W'(tail_sum);
    assign head_next = (r_head == IDX_W'(PENDING_DEPTH - 1)) ? '0 : r_head + IDX_W'(1);

    assign push_entry.notify      = i_notify;
    assign push_entry.tag         = i_requester_tag;
    assign push_entry.reg_address = i_reg_address;

    // Pushes and pops belong to different requests, which are never in flight together,
    // so a read never meets a write to the same entry in the same cycle.
    mdiocs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(PENDING_DEPTH)
    ) u_pending (
        .i_clk    (i_clk),
        .i_wr_en  (do_push),
        .i_wr_addr(tail),
        .i_wr_data(push_entry),
        .i_rd_en  (do_pop),
        .i_rd_addr(r_head),
        .o_rd_data(rd_data)
    );

    assign pop_entry = mdiocs_pkg::t_entry'(rd_data);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mdiocs_pkg::S_IDLE: begin
                if (accept) begin
                    if (is_write_req || do_push) begin
                        n_state = mdiocs_pkg::S_CMD;
                    end else if (is_read_req) begin
                        n_state = mdiocs_pkg::S_REFUSE;
                    end else if (do_pop) begin
                        n_state = mdiocs_pkg::S_POP;
                    end
                end
            end
            mdiocs_pkg::S_CMD: begin
                if (r_step == r_last_step) begin
                    n_state = mdiocs_pkg::S_IDLE;
                end
            end
            mdiocs_pkg::S_REFUSE: n_state = mdiocs_pkg::S_IDLE;
            mdiocs_pkg::S_POP:    n_state = mdiocs_pkg::S_IDLE;
            default:              n_state = mdiocs_pkg::S_IDLE;
        endcase
    end

    // Outputs
    logic                         n_strobe;
    logic [1:0]                   n_result_kind;
    logic [mdiocs_pkg::CMD_W-1:0] n_command_word;
    logic [15:0]                  n_done_reg_address;
    logic [15:0]                  n_done_value;
    logic [7:0]                   n_done_tag;
    logic                         n_last;

    logic                         r_strobe;
    logic [1:0]                   r_result_kind;
    logic [mdiocs_pkg::CMD_W-1:0] r_command_word;
    logic [15:0]                  r_done_reg_address;
    logic [15:0]                  r_done_value;
    logic [7:0]                   r_done_tag;
    logic                         r_last;

    always_comb begin
        n_strobe           = 1'b0;
        n_result_kind      = mdiocs_pkg::RES_COMMAND;
        n_command_word     = '0;
        n_done_reg_address = '0;
        n_done_value       = '0;
        n_done_tag         = '0;
        n_last             = 1'b0;
        unique case (r_state)
            mdiocs_pkg::S_IDLE: ;
            mdiocs_pkg::S_CMD: begin
                n_strobe       = 1'b1;
                n_command_word = mdiocs_pkg::f_cmd(r_phy_address, r_access_mode, r_is_read,
                                                   r_addr, r_data, r_step);
                n_last         = (r_step == r_last_step);
            end
            mdiocs_pkg::S_REFUSE: begin
                n_strobe      = 1'b1;
                n_result_kind = mdiocs_pkg::RES_REFUSED;
                n_last        = 1'b1;
            end
            mdiocs_pkg::S_POP: begin
                // An entry without notify leaves the queue silently.
                n_strobe           = pop_entry.notify;
                n_result_kind      = mdiocs_pkg::RES_DONE;
                n_done_reg_address = pop_entry.reg_address;
                n_done_value       = r_rdata;
                n_done_tag         = pop_entry.tag;
                n_last             = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mdiocs_pkg::S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (do_push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop) begin
                r_count <= r_count - CNT_W'(1);
                r_head  <= head_next;
            end
            if (accept) begin
                r_step <= '0;
            end else if (r_state == mdiocs_pkg::S_CMD) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read   <= is_read_req;
            r_addr      <= i_reg_address;
            r_data      <= i_write_data;
            r_rdata     <= i_status_read_data;
            r_last_step <= mdiocs_pkg::f_last_step(r_access_mode, i_reg_address);
        end
        r_result_kind      <= n_result_kind;
        r_command_word     <= n_command_word;
        r_done_reg_address <= n_done_reg_address;
        r_done_value       <= n_done_value;
        r_done_tag         <= n_done_tag;
        r_last             <= n_last;
    end

    assign o_strobe           = r_strobe;
    assign o_result_kind      = r_result_kind;
    assign o_command_word     = r_command_word;
    assign o_done_reg_address = r_done_reg_address;
    assign o_done_value       = r_done_value;
    assign o_done_tag         = r_done_tag;
    assign o_last             = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PENDING_DEPTH))
        else $error("pending count exceeds queue depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted read did not enter the pending queue");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) != mdiocs_pkg::S_IDLE)
        else $error("result strobe without an active request");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdiocs_pkg::S_CMD) |-> r_step <= r_last_step)
        else $error("command step ran past the last word");

    a_refuse_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result_kind == mdiocs_pkg::RES_REFUSED)
        |-> (r_last && r_command_word == '0))
        else $error("refused read carried a command word or was not final");

endmodule

FILE: hdl/mdiocs_ram.sv
`timescale 1ns / 1ps

module mdiocs_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
